// ===== design/bsc_pkg.sv =====
package bsc_pkg;

  localparam int COORD_W = 32;
  localparam int GRAD_W  = 48;
  localparam int IDX_W   = 10;
  localparam int COST_W  = 64;
  localparam int LIM_W   = 48;
  localparam int MUL_W   = 52;   // widest multiplier operand: the excess s
  localparam int HALF_W  = 32;
  localparam int ACC_W   = 2 * MUL_W;
  localparam int FRAC_W  = 16;
  localparam int DIFF_W  = COORD_W + 3;
  localparam int WIDE_W  = GRAD_W + 3;
  localparam int OP_W    = 4;

  localparam logic [OP_W-1:0] OP_JERK0  = 4'd0;
  localparam logic [OP_W-1:0] OP_CURV0  = 4'd3;
  localparam logic [OP_W-1:0] OP_EXCESS = 4'd6;
  localparam logic [OP_W-1:0] OP_GRAD0  = 4'd7;
  localparam logic [OP_W-1:0] OP_LAST   = 4'd9;

  localparam logic [IDX_W-1:0] IDX_MAX = {IDX_W{1'b1}};

  localparam logic signed [GRAD_W-1:0] GRAD_MAX = {1'b0, {(GRAD_W-1){1'b1}}};
  localparam logic signed [GRAD_W-1:0] GRAD_MIN = {1'b1, {(GRAD_W-1){1'b0}}};

  typedef struct packed {
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
    logic signed [COORD_W-1:0] coord_z;
    logic                      final_point;
  } in_item_t;

  typedef struct packed {
    logic signed [GRAD_W-1:0] grad_x;
    logic signed [GRAD_W-1:0] grad_y;
    logic signed [GRAD_W-1:0] grad_z;
    logic [IDX_W-1:0]         point_number;
    logic [COST_W-1:0]        total_cost;
    logic                     run_end;
  } out_item_t;

  typedef enum logic [1:0] {
    CLS_FILL   = 2'd0,   // one of the first three points, nothing to emit
    CLS_SHORT  = 2'd1,   // final point of a run under four points
    CLS_WINDOW = 2'd2,
    CLS_WFINAL = 2'd3
  } cls_t;

  typedef struct packed {
    in_item_t         pt;
    logic [IDX_W-1:0] n;
    cls_t             cls;
  } job_t;

  function automatic logic [COST_W-1:0] sat_add(input logic [COST_W-1:0] a,
                                                input logic [COST_W-1:0] b);
    logic [COST_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[COST_W] ? {COST_W{1'b1}} : s[COST_W-1:0];
  endfunction

  function automatic logic signed [GRAD_W-1:0] sat_grad(input logic signed [WIDE_W-1:0] v);
    logic signed [GRAD_W-1:0] r;
    if (v > WIDE_W'(GRAD_MAX)) begin
      r = GRAD_MAX;
    end else if (v < WIDE_W'(GRAD_MIN)) begin
      r = GRAD_MIN;
    end else begin
      r = v[GRAD_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== design/bspline_smoothness_cost.sv =====
// A point that only fills the history of a run is stored in the back end and emits nothing.
// A four-point window is loaded, then each product is issued to the shared 32x32
// multiplier and summed from four partial products: 6 products, 10 when curvature
// exceeds the limit, then gradient sums one axis at a time and one result out (four on
// the final point). The back end takes no new point until its results are queued.
// Synchronous active-low reset clears the run and sets the curvature limit to all ones.
module bspline_smoothness_cost (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_push,
  output logic                      in_full,
  input  bsc_pkg::in_item_t         in_item,
  output logic                      out_empty,
  input  logic                      out_pop,
  output bsc_pkg::out_item_t        out_item,
  input  logic                      cfg_we,
  input  logic [bsc_pkg::LIM_W-1:0] cfg_wdata
);

  bsc_pkg::job_t      job;
  logic               job_empty, job_pop;
  bsc_pkg::out_item_t res;
  logic               res_push, res_full;

  bsc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_item   (in_item),
    .job_pop   (job_pop),
    .job_empty (job_empty),
    .job       (job)
  );

  bsc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .job_empty (job_empty),
    .job_pop   (job_pop),
    .job       (job),
    .res_push  (res_push),
    .res_full  (res_full),
    .res       (res)
  );

  bsc_out_queue u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_push),
    .full      (res_full),
    .din       (res),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_item  (out_item)
  );

endmodule

// ===== design/bsc_front.sv =====
module bsc_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  output logic              in_full,
  input  bsc_pkg::in_item_t in_item,
  input  logic              job_pop,
  output logic              job_empty,
  output bsc_pkg::job_t     job
);

  bsc_pkg::job_t          q_r [2];
  logic                   wp_r, rp_r;
  logic [1:0]             cnt_r, cnt_nxt;
  logic [bsc_pkg::IDX_W-1:0] seen_r, seen_nxt;
  bsc_pkg::job_t          new_job;
  logic                   push_ok, pop_ok;

  assign in_full   = (cnt_r == 2'd2);
  assign job_empty = (cnt_r == 2'd0);
  assign job       = q_r[rp_r];
  assign push_ok   = in_push && !in_full;
  assign pop_ok    = job_pop && !job_empty;

  // classify against the running point count
  always_comb begin
    new_job.pt = in_item;
    new_job.n  = seen_r;
    seen_nxt   = seen_r;
    if (seen_r < bsc_pkg::IDX_W'(3)) begin
      new_job.cls = in_item.final_point ? bsc_pkg::CLS_SHORT : bsc_pkg::CLS_FILL;
      seen_nxt    = in_item.final_point ? '0 : seen_r + 1'b1;
    end else begin
      new_job.cls = in_item.final_point ? bsc_pkg::CLS_WFINAL : bsc_pkg::CLS_WINDOW;
      if (in_item.final_point) begin
        seen_nxt = '0;
      end else if (seen_r != bsc_pkg::IDX_MAX) begin
        seen_nxt = seen_r + 1'b1;
      end
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (push_ok && !pop_ok) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop_ok && !push_ok) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= 1'b0;
      rp_r   <= 1'b0;
      cnt_r  <= '0;
      seen_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push_ok) begin
        wp_r   <= ~wp_r;
        seen_r <= seen_nxt;
      end
      if (pop_ok) begin
        rp_r <= ~rp_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      q_r[wp_r] <= new_job;
    end
  end

endmodule

// ===== design/bsc_mul.sv =====
module bsc_mul (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [bsc_pkg::MUL_W-1:0]   a,
  input  logic [bsc_pkg::MUL_W-1:0]   b,
  output logic                        done,
  output logic [bsc_pkg::COST_W-1:0]  res
);

  logic [bsc_pkg::MUL_W-1:0]  a_r, b_r;
  logic [bsc_pkg::ACC_W-1:0]  acc_r;
  logic [1:0]                 cnt_r;
  logic                       busy_r, done_r;
  logic [bsc_pkg::HALF_W-1:0] opa, opb;
  logic [2*bsc_pkg::HALF_W-1:0] pp;
  logic [bsc_pkg::ACC_W-1:0]  pp_sh;

  // one 32x32 partial product a cycle, hi/lo halves chosen by the step count
  always_comb begin
    opa = cnt_r[1] ? bsc_pkg::HALF_W'(a_r[bsc_pkg::MUL_W-1:bsc_pkg::HALF_W])
                   : a_r[bsc_pkg::HALF_W-1:0];
    opb = cnt_r[0] ? bsc_pkg::HALF_W'(b_r[bsc_pkg::MUL_W-1:bsc_pkg::HALF_W])
                   : b_r[bsc_pkg::HALF_W-1:0];
    pp  = opa * opb;
    case (cnt_r)
      2'd0:    pp_sh = bsc_pkg::ACC_W'(pp);
      2'd3:    pp_sh = bsc_pkg::ACC_W'(pp) << (2 * bsc_pkg::HALF_W);
      default: pp_sh = bsc_pkg::ACC_W'(pp) << bsc_pkg::HALF_W;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 2'd1;
        if (cnt_r == 2'd3) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= a;
      b_r   <= b;
      acc_r <= '0;
    end else if (busy_r) begin
      acc_r <= acc_r + pp_sh;
    end
  end

  assign done = done_r;
  assign res  = (acc_r[bsc_pkg::ACC_W-1:bsc_pkg::COST_W+bsc_pkg::FRAC_W] != '0)
              ? {bsc_pkg::COST_W{1'b1}}
              : acc_r[bsc_pkg::COST_W+bsc_pkg::FRAC_W-1:bsc_pkg::FRAC_W];

endmodule

// ===== design/bsc_out_queue.sv =====
module bsc_out_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  bsc_pkg::out_item_t din,
  input  logic               out_pop,
  output logic               out_empty,
  output bsc_pkg::out_item_t out_item
);

  bsc_pkg::out_item_t q_r [4];
  logic [1:0]         wp_r, rp_r;
  logic [2:0]         cnt_r;
  logic               push_ok, pop_ok;

  assign full      = (cnt_r == 3'd4);
  assign out_empty = (cnt_r == 3'd0);
  assign out_item  = q_r[rp_r];
  assign push_ok   = push && !full;
  assign pop_ok    = out_pop && !out_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push_ok) begin
        wp_r <= wp_r + 2'd1;
      end
      if (pop_ok) begin
        rp_r <= rp_r + 2'd1;
      end
      if (push_ok && !pop_ok) begin
        cnt_r <= cnt_r + 3'd1;
      end else if (pop_ok && !push_ok) begin
        cnt_r <= cnt_r - 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      q_r[wp_r] <= din;
    end
  end

endmodule

// ===== design/bsc_back.sv =====
module bsc_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [bsc_pkg::LIM_W-1:0]  cfg_wdata,
  input  logic                       job_empty,
  output logic                       job_pop,
  input  bsc_pkg::job_t              job,
  output logic                       res_push,
  input  logic                       res_full,
  output bsc_pkg::out_item_t         res
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_ISSUE = 4'b0010,
    S_WAIT  = 4'b0100,
    S_EMIT  = 4'b1000
  } state_t;

  localparam int GW = bsc_pkg::GRAD_W;
  localparam int WW = bsc_pkg::WIDE_W;
  localparam logic [GW-1:0] GRAD_TOP = {1'b1, {(GW-1){1'b0}}};

  state_t                       state_r;
  bsc_pkg::job_t                item_r;
  logic [bsc_pkg::LIM_W-1:0]    limit_r;
  logic signed [bsc_pkg::COORD_W-1:0] hist_r [3][3];
  logic signed [GW-1:0]         pend_r [3][3];
  logic signed [GW-1:0]         g_r [3][4];
  logic signed [GW-1:0]         d_r [3];
  logic [bsc_pkg::COST_W-1:0]   cost_r, csq_r, csq_nxt;
  logic [bsc_pkg::MUL_W-1:0]    s_r;
  logic [bsc_pkg::OP_W-1:0]     op_r;
  logic [1:0]                   ax_r, k_r, last_r, op_ax;
  logic                         grad_r;

  logic signed [bsc_pkg::COORD_W-1:0] pt [3];
  logic signed [bsc_pkg::DIFF_W-1:0]  jv [3], cv [3];
  logic [bsc_pkg::DIFF_W-1:0]         jm [3], cm [3];
  logic [bsc_pkg::MUL_W-1:0]          mul_a, mul_b;
  logic                               mul_done;
  logic [bsc_pkg::COST_W-1:0]         mul_res;
  logic [GW-1:0]                      m_clamp;
  logic signed [WW-1:0]               d_wide;
  logic signed [GW-1:0]               d_new;
  logic signed [WW-1:0]               j_w, dd_w;
  logic signed [GW-1:0]               g0, g1, g2, g3;
  logic                               emit_go, emit_done;

  assign pt[0] = item_r.pt.coord_x;
  assign pt[1] = item_r.pt.coord_y;
  assign pt[2] = item_r.pt.coord_z;

  // jerk and second difference of the window, per axis
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      jv[a] = bsc_pkg::DIFF_W'(pt[a])
            - 3 * bsc_pkg::DIFF_W'(hist_r[a][2])
            + 3 * bsc_pkg::DIFF_W'(hist_r[a][1])
            - bsc_pkg::DIFF_W'(hist_r[a][0]);
      cv[a] = bsc_pkg::DIFF_W'(hist_r[a][0])
            - 2 * bsc_pkg::DIFF_W'(hist_r[a][1])
            + bsc_pkg::DIFF_W'(hist_r[a][2]);
      jm[a] = jv[a][bsc_pkg::DIFF_W-1] ? -jv[a] : jv[a];
      cm[a] = cv[a][bsc_pkg::DIFF_W-1] ? -cv[a] : cv[a];
    end
  end

  always_comb begin
    if (op_r < bsc_pkg::OP_CURV0) begin
      op_ax = op_r[1:0];
    end else if (op_r < bsc_pkg::OP_EXCESS) begin
      op_ax = 2'(op_r - bsc_pkg::OP_CURV0);
    end else if (op_r == bsc_pkg::OP_EXCESS) begin
      op_ax = 2'd0;
    end else begin
      op_ax = 2'(op_r - bsc_pkg::OP_GRAD0);
    end
  end

  always_comb begin
    if (op_r < bsc_pkg::OP_CURV0) begin
      mul_a = bsc_pkg::MUL_W'(jm[op_ax]);
      mul_b = bsc_pkg::MUL_W'(jm[op_ax]);
    end else if (op_r < bsc_pkg::OP_EXCESS) begin
      mul_a = bsc_pkg::MUL_W'(cm[op_ax]);
      mul_b = bsc_pkg::MUL_W'(cm[op_ax]);
    end else if (op_r == bsc_pkg::OP_EXCESS) begin
      mul_a = s_r;
      mul_b = s_r;
    end else begin
      mul_a = s_r;
      mul_b = bsc_pkg::MUL_W'(cm[op_ax]);
    end
  end

  bsc_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (state_r == S_ISSUE),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .res   (mul_res)
  );

  assign csq_nxt = bsc_pkg::sat_add(csq_r, mul_res);

  // curvature gradient term d = +-4 * min(s|c|, 2^47)
  always_comb begin
    if (mul_res > bsc_pkg::COST_W'(GRAD_TOP)) begin
      m_clamp = GRAD_TOP;
    end else begin
      m_clamp = mul_res[GW-1:0];
    end
    d_wide = cv[op_ax][bsc_pkg::DIFF_W-1] ? -(WW'(m_clamp) <<< 2) : (WW'(m_clamp) <<< 2);
    d_new  = bsc_pkg::sat_grad(d_wide);
  end

  // gradient sums for one axis
  always_comb begin
    j_w  = WW'(jv[ax_r]);
    dd_w = WW'(d_r[ax_r]);
    g0 = bsc_pkg::sat_grad(WW'(pend_r[ax_r][0]) - 2 * j_w);
    g1 = bsc_pkg::sat_grad(WW'(pend_r[ax_r][1]) + 6 * j_w);
    g2 = bsc_pkg::sat_grad(WW'(pend_r[ax_r][2]) - 6 * j_w);
    g3 = bsc_pkg::sat_grad(2 * j_w);
    g0 = bsc_pkg::sat_grad(WW'(g0) + dd_w);
    g1 = bsc_pkg::sat_grad(WW'(g1) + WW'(bsc_pkg::sat_grad(-2 * dd_w)));
    g2 = bsc_pkg::sat_grad(WW'(g2) + dd_w);
  end

  always_comb begin
    res = '0;
    if (item_r.cls == bsc_pkg::CLS_SHORT) begin
      res.point_number = bsc_pkg::IDX_W'(k_r);
      res.run_end      = (k_r == last_r);
    end else begin
      res.grad_x       = g_r[0][k_r];
      res.grad_y       = g_r[1][k_r];
      res.grad_z       = g_r[2][k_r];
      res.point_number = item_r.n - bsc_pkg::IDX_W'(3) + bsc_pkg::IDX_W'(k_r);
      res.run_end      = (k_r == 2'd3);
      res.total_cost   = (k_r == 2'd3) ? cost_r : '0;
    end
  end

  assign job_pop   = (state_r == S_IDLE) && !job_empty;
  assign emit_go   = (state_r == S_EMIT) && !grad_r;
  assign res_push  = emit_go;
  assign emit_done = emit_go && !res_full && (k_r == last_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      limit_r <= {bsc_pkg::LIM_W{1'b1}};
      cost_r  <= '0;
      grad_r  <= 1'b0;
      op_r    <= '0;
      ax_r    <= '0;
      k_r     <= '0;
      last_r  <= '0;
      for (int a = 0; a < 3; a++) begin
        for (int i = 0; i < 3; i++) begin
          pend_r[a][i] <= '0;
        end
      end
    end else begin
      if (cfg_we) begin
        limit_r <= cfg_wdata;
      end
      unique case (state_r)
        S_IDLE: begin
          if (!job_empty) begin
            item_r <= job;
            op_r   <= bsc_pkg::OP_JERK0;
            k_r    <= '0;
            ax_r   <= '0;
            csq_r  <= '0;
            for (int a = 0; a < 3; a++) begin
              d_r[a] <= '0;
            end
            case (job.cls)
              bsc_pkg::CLS_FILL: begin
                hist_r[0][job.n[1:0]] <= job.pt.coord_x;
                hist_r[1][job.n[1:0]] <= job.pt.coord_y;
                hist_r[2][job.n[1:0]] <= job.pt.coord_z;
              end
              bsc_pkg::CLS_SHORT: begin
                last_r  <= job.n[1:0];
                grad_r  <= 1'b0;
                state_r <= S_EMIT;
              end
              default: begin
                last_r  <= job.pt.final_point ? 2'd3 : 2'd0;
                state_r <= S_ISSUE;
              end
            endcase
          end
        end
        S_ISSUE: begin
          state_r <= S_WAIT;
        end
        S_WAIT: begin
          if (mul_done) begin
            op_r <= op_r + 1'b1;
            // curvature within the limit skips the excess products
            if (op_r == bsc_pkg::OP_LAST ||
                (op_r == bsc_pkg::OP_EXCESS - 1'b1 &&
                 csq_nxt <= bsc_pkg::COST_W'(limit_r))) begin
              grad_r  <= 1'b1;
              state_r <= S_EMIT;
            end else begin
              state_r <= S_ISSUE;
            end
            if (op_r < bsc_pkg::OP_CURV0) begin
              cost_r <= bsc_pkg::sat_add(cost_r, mul_res);
            end else if (op_r < bsc_pkg::OP_EXCESS) begin
              csq_r <= csq_nxt;
              if (op_r == bsc_pkg::OP_EXCESS - 1'b1) begin
                s_r <= bsc_pkg::MUL_W'(csq_nxt - bsc_pkg::COST_W'(limit_r));
              end
            end else if (op_r == bsc_pkg::OP_EXCESS) begin
              cost_r <= bsc_pkg::sat_add(cost_r, mul_res);
            end else begin
              d_r[op_ax] <= d_new;
            end
          end
        end
        S_EMIT: begin
          if (grad_r) begin
            // gradient sums one axis at a time, all three axes before emitting
            g_r[ax_r][0] <= g0;
            g_r[ax_r][1] <= g1;
            g_r[ax_r][2] <= g2;
            g_r[ax_r][3] <= g3;
            ax_r <= ax_r + 2'd1;
            if (ax_r == 2'd2) begin
              grad_r <= 1'b0;
            end
          end else if (!res_full) begin
            k_r <= k_r + 2'd1;
            if (emit_done) begin
              state_r <= S_IDLE;
              if (item_r.cls == bsc_pkg::CLS_WINDOW) begin
                for (int a = 0; a < 3; a++) begin
                  hist_r[a][0] <= hist_r[a][1];
                  hist_r[a][1] <= hist_r[a][2];
                  hist_r[a][2] <= pt[a];
                  pend_r[a][0] <= g_r[a][1];
                  pend_r[a][1] <= g_r[a][2];
                  pend_r[a][2] <= g_r[a][3];
                end
              end else begin
                cost_r <= '0;
                for (int a = 0; a < 3; a++) begin
                  for (int i = 0; i < 3; i++) begin
                    pend_r[a][i] <= '0;
                  end
                end
              end
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== tb/tb_bspline_smoothness_cost.sv =====
`timescale 1ns / 100ps

module tb_bspline_smoothness_cost;

  localparam int NUM_RANDOM_RUNS = 28;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_push = 1'b0;
  logic in_full;
  bsc_pkg::in_item_t in_item = '0;
  logic out_empty;
  logic out_pop = 1'b0;
  bsc_pkg::out_item_t out_item;
  logic cfg_we = 1'b0;
  logic [bsc_pkg::LIM_W-1:0] cfg_wdata = '0;

  always #5 clk = ~clk;

  bspline_smoothness_cost i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full), .in_item(in_item),
    .out_empty(out_empty), .out_pop(out_pop), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  // predictor state
  logic [bsc_pkg::LIM_W-1:0] curv_limit;
  longint hist_pt [3][3];
  longint pend_grad [3][3];
  int unsigned pts_seen;
  logic [63:0] cost_acc;

  bsc_pkg::in_item_t point_queue [$];
  bsc_pkg::out_item_t expected_grads [$];
  int errors = 0;

  bit accepted_last = 1'b0;
  int stall_mode = 0;
  int stall_count = 0;
  int burst_left = 0;
  int gap_left = 0;

  task automatic report_mismatch(input string what);
    errors++;
    $display("%0t: mismatch: %s", $realtime, what);
  endtask

  function automatic void add_expected(input bsc_pkg::out_item_t it);
    expected_grads = {expected_grads, it};
  endfunction

  function automatic void add_point(input bsc_pkg::in_item_t it);
    point_queue = {point_queue, it};
  endfunction

  function automatic logic [63:0] cost_add(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? 64'hFFFF_FFFF_FFFF_FFFF : s[63:0];
  endfunction

  function automatic longint clamp_grad(input longint v);
    if (v > 64'sd140737488355327) return 64'sd140737488355327;
    if (v < -64'sd140737488355328) return -64'sd140737488355328;
    return v;
  endfunction

  function automatic logic [63:0] fx_mul(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    p = p >> bsc_pkg::FRAC_W;
    return (p[127:64] != 0) ? 64'hFFFF_FFFF_FFFF_FFFF : p[63:0];
  endfunction

  function automatic logic [63:0] magn(input longint v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  function automatic bsc_pkg::out_item_t grad_item(input longint gx, gy, gz,
                                                   input int unsigned idx,
                                                   input logic [63:0] cost, input bit last);
    bsc_pkg::out_item_t r;
    r.grad_x = gx[bsc_pkg::GRAD_W-1:0];
    r.grad_y = gy[bsc_pkg::GRAD_W-1:0];
    r.grad_z = gz[bsc_pkg::GRAD_W-1:0];
    r.point_number = idx[bsc_pkg::IDX_W-1:0];
    r.total_cost = cost;
    r.run_end = last;
    return r;
  endfunction

  task automatic clear_trajectory();
    for (int a = 0; a < 3; a++)
      for (int i = 0; i < 3; i++) begin
        hist_pt[a][i] = 0;
        pend_grad[a][i] = 0;
      end
    pts_seen = 0;
    cost_acc = '0;
  endtask

  task automatic predict_point(input bsc_pkg::in_item_t it);
    longint p [3];
    longint g [3][4];
    longint cv [3];
    longint j, d;
    logic [63:0] jsum, csq, s, m;
    int unsigned n;
    n = pts_seen;
    p[0] = longint'(it.coord_x);
    p[1] = longint'(it.coord_y);
    p[2] = longint'(it.coord_z);
    jsum = '0;
    csq = '0;
    if (n < 3) begin
      for (int a = 0; a < 3; a++) hist_pt[a][n] = p[a];
      if (!it.final_point) begin
        pts_seen = n + 1;
        return;
      end
      // short trajectory: zero gradients, no cost
      for (int k = 0; k <= n; k++)
        add_expected(grad_item(0, 0, 0, k, '0, k == n));
      clear_trajectory();
      return;
    end
    for (int a = 0; a < 3; a++) begin
      j = p[a] - 3 * hist_pt[a][2] + 3 * hist_pt[a][1] - hist_pt[a][0];
      jsum = cost_add(jsum, fx_mul(magn(j), magn(j)));
      g[a][0] = clamp_grad(pend_grad[a][0] - 2 * j);
      g[a][1] = clamp_grad(pend_grad[a][1] + 6 * j);
      g[a][2] = clamp_grad(pend_grad[a][2] - 6 * j);
      g[a][3] = clamp_grad(2 * j);
      cv[a] = hist_pt[a][0] - 2 * hist_pt[a][1] + hist_pt[a][2];
      csq = cost_add(csq, fx_mul(magn(cv[a]), magn(cv[a])));
    end
    cost_acc = cost_add(cost_acc, jsum);
    if (csq > {16'd0, curv_limit}) begin
      s = csq - {16'd0, curv_limit};
      cost_acc = cost_add(cost_acc, fx_mul(s, s));
      for (int a = 0; a < 3; a++) begin
        m = fx_mul(s, magn(cv[a]));
        if (m > 64'h8000_0000_0000) m = 64'h8000_0000_0000;
        d = longint'(m * 4);
        d = clamp_grad(cv[a] < 0 ? -d : d);
        g[a][0] = clamp_grad(g[a][0] + d);
        g[a][1] = clamp_grad(g[a][1] + clamp_grad(-2 * d));
        g[a][2] = clamp_grad(g[a][2] + d);
      end
    end
    add_expected(grad_item(g[0][0], g[1][0], g[2][0], n - 3, '0, 1'b0));
    if (it.final_point) begin
      for (int k = 1; k <= 3; k++)
        add_expected(grad_item(g[0][k], g[1][k], g[2][k], n - 3 + k,
                               k == 3 ? cost_acc : 64'd0, k == 3));
      clear_trajectory();
      return;
    end
    for (int a = 0; a < 3; a++) begin
      hist_pt[a][0] = hist_pt[a][1];
      hist_pt[a][1] = hist_pt[a][2];
      hist_pt[a][2] = p[a];
      pend_grad[a][0] = g[a][1];
      pend_grad[a][1] = g[a][2];
      pend_grad[a][2] = g[a][3];
    end
    if (n < 1023) pts_seen = n + 1;
  endtask

  function automatic logic [31:0] rand_coord(input int mode);
    case (mode)
      0: return $urandom;
      1: return 32'(int'($urandom_range(0, 2 ** 20)) - 2 ** 19);
      2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return 32'(int'($urandom_range(0, 2 ** 17)) - 2 ** 16);
    endcase
  endfunction

  function automatic bsc_pkg::in_item_t make_point(input logic [31:0] x, y, z, input bit fin);
    bsc_pkg::in_item_t it;
    it.coord_x = x;
    it.coord_y = y;
    it.coord_z = z;
    it.final_point = fin;
    return it;
  endfunction

  task automatic queue_run(input int len, input int mode);
    for (int i = 0; i < len; i++)
      add_point(make_point(rand_coord(mode), rand_coord(mode), rand_coord(mode),
                           i == len - 1));
  endtask

  task automatic drain();
    while (point_queue.size() != 0 || expected_grads.size() != 0 || in_push)
      @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_limit(input logic [bsc_pkg::LIM_W-1:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    curv_limit = v;
  endtask

  // driver: bursts and gaps
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_push || accepted_last) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_push <= 1'b0;
        end else if (point_queue.size() != 0) begin
          in_item <= point_queue.pop_front();
          in_push <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 12);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_push <= 1'b0;
        end
      end
      // receiver stall pattern
      case (stall_mode)
        0: out_pop <= 1'b1;
        1: out_pop <= ($urandom_range(0, 3) != 0);
        default: out_pop <= ($urandom_range(0, 5) == 0);
      endcase
    end
  end

  // monitor
  always @(posedge clk) begin
    accepted_last = 1'b0;
    if (rst_n) begin
      if (in_push && !in_full) begin
        predict_point(in_item);
        accepted_last = 1'b1;
      end
      if (out_pop && !out_empty) begin
        if (expected_grads.size() == 0) begin
          report_mismatch("unexpected result item");
        end else begin
          bsc_pkg::out_item_t e;
          e = expected_grads.pop_front();
          if (out_item.grad_x !== e.grad_x)
            report_mismatch($sformatf("grad_x %h exp %h", out_item.grad_x, e.grad_x));
          if (out_item.grad_y !== e.grad_y)
            report_mismatch($sformatf("grad_y %h exp %h", out_item.grad_y, e.grad_y));
          if (out_item.grad_z !== e.grad_z)
            report_mismatch($sformatf("grad_z %h exp %h", out_item.grad_z, e.grad_z));
          if (out_item.point_number !== e.point_number)
            report_mismatch($sformatf("point_number %0d exp %0d",
                                      out_item.point_number, e.point_number));
          if (out_item.total_cost !== e.total_cost)
            report_mismatch($sformatf("total_cost %h exp %h",
                                      out_item.total_cost, e.total_cost));
          if (out_item.run_end !== e.run_end)
            report_mismatch($sformatf("run_end %b exp %b", out_item.run_end, e.run_end));
        end
      end
      if (stall_count == 0) begin
        stall_mode = $urandom_range(0, 2);
        stall_count = $urandom_range(20, 300);
      end else begin
        stall_count--;
      end
    end
  end

  initial begin
    clear_trajectory();
    curv_limit = {bsc_pkg::LIM_W{1'b1}};
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: short trajectories of one, two, three points
    add_point(make_point(32'h7FFF_FFFF, 32'h8000_0000, 0, 1'b1));
    add_point(make_point(1, 2, 3, 1'b0));
    add_point(make_point(-1, -2, -3, 1'b1));
    queue_run(3, 0);
    // exactly four points, extremes alternating: maximum jerk magnitude on every axis
    add_point(make_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0));
    add_point(make_point(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0));
    add_point(make_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0));
    add_point(make_point(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1));
    queue_run(8, 3);
    drain();

    // curvature penalty active at the lowest limit
    write_limit('0);
    queue_run(6, 3);
    queue_run(5, 2);
    queue_run(7, 0);
    drain();

    for (int r = 0; r < NUM_RANDOM_RUNS; r++) begin
      if (r % 8 == 0) begin
        drain();
        case (r / 8)
          0: write_limit({bsc_pkg::LIM_W{1'b1}});
          1: write_limit(48'd1 << $urandom_range(10, 40));
          2: write_limit(bsc_pkg::LIM_W'($urandom_range(0, 2 ** 18)));
          default: write_limit(bsc_pkg::LIM_W'({$urandom, $urandom}));
        endcase
      end
      if ($urandom_range(0, 9) == 0) queue_run($urandom_range(1, 3), $urandom_range(0, 3));
      else queue_run($urandom_range(4, 9), $urandom_range(0, 3));
    end
    drain();
    if (errors == 0) begin
      $display("PASS bspline_smoothness_cost");
    end else begin
      $display("FAIL bspline_smoothness_cost");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("FAIL bspline_smoothness_cost");
    $finish;
  end

endmodule

// ===== sim.f =====
design/bsc_pkg.sv
design/bsc_front.sv
design/bsc_mul.sv
design/bsc_out_queue.sv
design/bsc_back.sv
design/bspline_smoothness_cost.sv
tb/tb_bspline_smoothness_cost.sv
